// File: hdl/ppalh_pkg.sv
package ppalh_pkg;

    localparam int FRAME_W    = 20;
    localparam int PEAK_BIN_W = 12;
    localparam int FAN_W      = 4;
    localparam int GAP_W      = 10;
    localparam int HASH_W     = 32;

    // Fingerprints allowed per peak, and a count wide enough to hold it
    localparam int MAX_RESULTS = 32;
    localparam int RES_CNT_W   = $clog2(MAX_RESULTS + 1);

    localparam logic [HASH_W-1:0] HASH_MUL = 32'd1000003;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_FAN_OUT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_GAP = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_GAP = 2'd2;

    localparam logic [FAN_W-1:0] FAN_OUT_RST = 4'd5;
    localparam logic [GAP_W-1:0] MIN_GAP_RST = 10'd1;
    localparam logic [GAP_W-1:0] MAX_GAP_RST = 10'd64;

    // Control into one anchor cell
    typedef struct packed {
        logic shift;
        logic clear;
    } t_cell_ctrl;

endpackage

// File: hdl/peak_pair_landmark_hasher_core.sv
// Landmark hasher for spectral peaks.
// Input channel (i_peak_valid / o_peak_ready): one peak per transfer, with
// frame, bin and a start-of-signal flag; peaks must come in (frame, bin) order.
// Output channel (o_hash_valid / i_hash_ready): one fingerprint per transfer,
// with the hash, the anchor frame and a flag on the last one of each peak.
// Anchors live in a chain of ANCHOR_DEPTH cells, oldest at cell 0. A peak is
// handled by a scan, in which the chain rotates once and cell 0 is checked
// against the peak at every step, then by an insert step that drops the oldest
// anchor and shifts the peak in. Each fingerprint is held until the next one
// of its peak is found, the last one until the insert cycle so it can carry
// the flag; after its release it passes through the stage-1 register and the
// output register of the hash pipeline.
// When the receiver stalls, the hash pipeline fills and the scan holds; no
// fingerprint is lost. Peaks are taken only while no scan is running.
// Reset empties the chain and loads fan-out 5, gap range 1 to 64. Config
// writes (i_cfg_we, i_cfg_idx, i_cfg_data) take effect at once and must only
// happen while the block is idle.
module peak_pair_landmark_hasher_core
    import ppalh_pkg::*;
#(
    parameter int ANCHOR_DEPTH = 32,
    parameter int BIN_BITS     = 12
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [GAP_W-1:0]      i_cfg_data,
    input  logic                  i_peak_valid,
    output logic                  o_peak_ready,
    input  logic [FRAME_W-1:0]    i_peak_frame,
    input  logic [PEAK_BIN_W-1:0] i_peak_bin,
    input  logic                  i_start_of_signal,
    output logic                  o_hash_valid,
    input  logic                  i_hash_ready,
    output logic [HASH_W-1:0]     o_pair_hash,
    output logic [FRAME_W-1:0]    o_anchor_frame,
    output logic                  o_last_of_run
);

    localparam int SCAN_W = $clog2(ANCHOR_DEPTH);
    localparam logic [SCAN_W-1:0] SCAN_LAST = SCAN_W'(ANCHOR_DEPTH - 1);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_INSERT = 2'd2;

    logic [1:0]           r_state;
    logic [SCAN_W-1:0]    r_scan_cnt;
    logic [RES_CNT_W-1:0] r_nres;
    logic [FAN_W-1:0]     r_fan_out;
    logic [GAP_W-1:0]     r_min_gap;
    logic [GAP_W-1:0]     r_max_gap;
    logic [FRAME_W-1:0]   r_pk_frame;
    logic [BIN_BITS-1:0]  r_pk_bin;
    logic                 r_pend_valid;
    logic [BIN_BITS-1:0]  r_pend_abin;
    logic [GAP_W-1:0]     r_pend_gap;
    logic [FRAME_W-1:0]   r_pend_frame;

    logic [FRAME_W-1:0]  w_frame [ANCHOR_DEPTH];
    logic [BIN_BITS-1:0] w_bin   [ANCHOR_DEPTH];
    logic [FAN_W-1:0]    w_cnt   [ANCHOR_DEPTH];
    logic                w_live  [ANCHOR_DEPTH];

    logic [PEAK_BIN_W+BIN_BITS-1:0] w_bin_wide;
    logic                w_in_acc;
    logic                w_s1_ready;
    logic                w_step;
    t_cell_ctrl          w_ctrl;
    logic [FRAME_W-1:0]  w_gap_full;
    logic                w_emit;
    logic                w_keep;
    logic [FAN_W-1:0]    w_cnt_inc;
    logic [FRAME_W-1:0]  w_tail_frame;
    logic [BIN_BITS-1:0] w_tail_bin;
    logic [FAN_W-1:0]    w_tail_cnt;
    logic                w_tail_live;
    logic                w_push;
    logic                w_push_last;

    assign o_peak_ready = (r_state == ST_IDLE);
    assign w_in_acc     = i_peak_valid && o_peak_ready;
    // Use the low BIN_BITS of the bin, zero-extend when the field is narrower
    assign w_bin_wide   = (PEAK_BIN_W + BIN_BITS)'(i_peak_bin);

    // The chain moves only when the hash pipeline can take a fingerprint
    assign w_step = ((r_state == ST_SCAN) || (r_state == ST_INSERT)) && w_s1_ready;
    assign w_ctrl.shift = w_step;
    assign w_ctrl.clear = w_in_acc && i_start_of_signal;

    // Judge the oldest anchor against the current peak
    assign w_gap_full = r_pk_frame - w_frame[0];
    assign w_cnt_inc  = w_cnt[0] + FAN_W'(1);

    always_comb begin
        w_emit = 1'b0;
        w_keep = w_live[0];
        priority if (!w_live[0]) begin
            w_keep = 1'b0;
        end else if (w_cnt[0] >= r_fan_out) begin
            w_keep = 1'b0;
        end else if (w_frame[0] > r_pk_frame) begin
            w_keep = 1'b1;
        end else if (w_gap_full > FRAME_W'(r_max_gap)) begin
            w_keep = 1'b0;
        end else if ((w_gap_full < FRAME_W'(r_min_gap))
                     || (r_nres >= RES_CNT_W'(MAX_RESULTS))) begin
            w_keep = 1'b1;
        end else begin
            w_emit = 1'b1;
            w_keep = (w_cnt_inc < r_fan_out);
        end
    end

    // Tail of the chain: rotated anchor while scanning, the new peak on insert
    always_comb begin
        if (r_state == ST_INSERT) begin
            w_tail_frame = r_pk_frame;
            w_tail_bin   = r_pk_bin;
            w_tail_cnt   = '0;
            w_tail_live  = 1'b1;
        end else begin
            w_tail_frame = w_frame[0];
            w_tail_bin   = w_bin[0];
            w_tail_cnt   = w_emit ? w_cnt_inc : w_cnt[0];
            w_tail_live  = w_keep;
        end
    end

    // Release the held fingerprint when a newer one arrives or the scan ends
    assign w_push = w_step && r_pend_valid && ((r_state == ST_INSERT) || w_emit);
    assign w_push_last = (r_state == ST_INSERT);

    genvar g;
    generate
        for (g = 0; g < ANCHOR_DEPTH; g++) begin : g_cell
            if (g == ANCHOR_DEPTH - 1) begin : g_tail
                ppalh_cell #(
                    .BIN_BITS (BIN_BITS)
                ) u_cell (
                    .i_clk   (i_clk),
                    .i_rst_n (i_rst_n),
                    .i_ctrl  (w_ctrl),
                    .i_frame (w_tail_frame),
                    .i_bin   (w_tail_bin),
                    .i_cnt   (w_tail_cnt),
                    .i_live  (w_tail_live),
                    .o_frame (w_frame[g]),
                    .o_bin   (w_bin[g]),
                    .o_cnt   (w_cnt[g]),
                    .o_live  (w_live[g])
                );
            end else begin : g_body
                ppalh_cell #(
                    .BIN_BITS (BIN_BITS)
                ) u_cell (
                    .i_clk   (i_clk),
                    .i_rst_n (i_rst_n),
                    .i_ctrl  (w_ctrl),
                    .i_frame (w_frame[g+1]),
                    .i_bin   (w_bin[g+1]),
                    .i_cnt   (w_cnt[g+1]),
                    .i_live  (w_live[g+1]),
                    .o_frame (w_frame[g]),
                    .o_bin   (w_bin[g]),
                    .o_cnt   (w_cnt[g]),
                    .o_live  (w_live[g])
                );
            end
        end
    endgenerate

    ppalh_hash #(
        .BIN_BITS (BIN_BITS)
    ) u_hash (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_abin  (r_pend_abin),
        .i_tbin  (r_pk_bin),
        .i_gap   (r_pend_gap),
        .i_frame (r_pend_frame),
        .i_last  (w_push_last),
        .o_ready (w_s1_ready),
        .o_valid (o_hash_valid),
        .i_ready (i_hash_ready),
        .o_hash  (o_pair_hash),
        .o_frame (o_anchor_frame),
        .o_last  (o_last_of_run)
    );

    // Control: sequencer, result count, held-fingerprint flag, registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_scan_cnt   <= '0;
            r_nres       <= '0;
            r_pend_valid <= 1'b0;
            r_fan_out    <= FAN_OUT_RST;
            r_min_gap    <= MIN_GAP_RST;
            r_max_gap    <= MAX_GAP_RST;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_FAN_OUT: r_fan_out <= i_cfg_data[FAN_W-1:0];
                    CFG_MIN_GAP: r_min_gap <= i_cfg_data;
                    CFG_MAX_GAP: r_max_gap <= i_cfg_data;
                    default: ;
                endcase
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (w_in_acc) begin
                        r_state    <= ST_SCAN;
                        r_scan_cnt <= '0;
                        r_nres     <= '0;
                    end
                end
                ST_SCAN: begin
                    if (w_step) begin
                        if (w_emit) begin
                            r_pend_valid <= 1'b1;
                            r_nres       <= r_nres + RES_CNT_W'(1);
                        end
                        if (r_scan_cnt == SCAN_LAST) begin
                            r_state <= ST_INSERT;
                        end else begin
                            r_scan_cnt <= r_scan_cnt + SCAN_W'(1);
                        end
                    end
                end
                ST_INSERT: begin
                    if (w_step) begin
                        r_pend_valid <= 1'b0;
                        r_state      <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // Hold the accepted peak and the newest candidate fingerprint
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_pk_frame <= i_peak_frame;
            r_pk_bin   <= w_bin_wide[BIN_BITS-1:0];
        end
        if ((r_state == ST_SCAN) && w_step && w_emit) begin
            r_pend_abin  <= w_bin[0];
            r_pend_gap   <= w_gap_full[GAP_W-1:0];
            r_pend_frame <= w_frame[0];
        end
    end

endmodule

// File: hdl/ppalh_cell.sv
module ppalh_cell
    import ppalh_pkg::*;
#(
    parameter int BIN_BITS = 12
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cell_ctrl          i_ctrl,
    input  logic [FRAME_W-1:0]  i_frame,
    input  logic [BIN_BITS-1:0] i_bin,
    input  logic [FAN_W-1:0]    i_cnt,
    input  logic                i_live,
    output logic [FRAME_W-1:0]  o_frame,
    output logic [BIN_BITS-1:0] o_bin,
    output logic [FAN_W-1:0]    o_cnt,
    output logic                o_live
);

    logic [FRAME_W-1:0]  r_frame;
    logic [BIN_BITS-1:0] r_bin;
    logic [FAN_W-1:0]    r_cnt;
    logic                r_live;

    // Live flag: cleared by reset and start of signal, else loaded from its input on a shift
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_live <= 1'b0;
        end else begin
            priority if (i_ctrl.clear) begin
                r_live <= 1'b0;
            end else if (i_ctrl.shift) begin
                r_live <= i_live;
            end else begin
                r_live <= r_live;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.shift) begin
            r_frame <= i_frame;
            r_bin   <= i_bin;
            r_cnt   <= i_cnt;
        end
    end

    assign o_frame = r_frame;
    assign o_bin   = r_bin;
    assign o_cnt   = r_cnt;
    assign o_live  = r_live;

endmodule

// File: hdl/ppalh_hash.sv
module ppalh_hash
    import ppalh_pkg::*;
#(
    parameter int BIN_BITS = 12
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  logic [BIN_BITS-1:0] i_abin,
    input  logic [BIN_BITS-1:0] i_tbin,
    input  logic [GAP_W-1:0]    i_gap,
    input  logic [FRAME_W-1:0]  i_frame,
    input  logic                i_last,
    output logic                o_ready,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [HASH_W-1:0]   o_hash,
    output logic [FRAME_W-1:0]  o_frame,
    output logic                o_last
);

    logic                r_s1_valid;
    logic [HASH_W-1:0]   r_s1_h1;
    logic [GAP_W-1:0]    r_s1_gap;
    logic [FRAME_W-1:0]  r_s1_frame;
    logic                r_s1_last;
    logic                r_o_valid;
    logic [HASH_W-1:0]   r_o_hash;
    logic [FRAME_W-1:0]  r_o_frame;
    logic                r_o_last;
    logic                w_out_ready;
    logic                w_s1_ready;
    logic [HASH_W-1:0]   n_s1_h1;
    logic [HASH_W-1:0]   n_o_hash;

    assign w_out_ready = !r_o_valid || i_ready;
    assign w_s1_ready  = !r_s1_valid || w_out_ready;

    // First round: anchor bin times the multiplier plus target bin
    assign n_s1_h1  = HASH_W'(i_abin) * HASH_MUL + HASH_W'(i_tbin);
    // Second round: fold in the frame gap
    assign n_o_hash = r_s1_h1 * HASH_MUL + HASH_W'(r_s1_gap);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            if (w_s1_ready) begin
                r_s1_valid <= i_push;
            end
            if (w_out_ready) begin
                r_o_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_ready && i_push) begin
            r_s1_h1    <= n_s1_h1;
            r_s1_gap   <= i_gap;
            r_s1_frame <= i_frame;
            r_s1_last  <= i_last;
        end
        if (w_out_ready && r_s1_valid) begin
            r_o_hash  <= n_o_hash;
            r_o_frame <= r_s1_frame;
            r_o_last  <= r_s1_last;
        end
    end

    assign o_ready = w_s1_ready;
    assign o_valid = r_o_valid;
    assign o_hash  = r_o_hash;
    assign o_frame = r_o_frame;
    assign o_last  = r_o_last;

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import ppalh_pkg::*;

    localparam int N_ANCHORS  = 32;
    localparam int RAND_ITEMS = 330;
    localparam int IDLE_PCT   = 19;

    typedef enum logic [0:0] {ROW_PEAK, ROW_REG} t_row_kind;

    // One line of the directed table: either a peak transfer or a register write.
    // Rows marked known carry their fingerprint outcome typed in by hand.
    typedef struct packed {
        t_row_kind              kind;
        logic [CFG_IDX_W-1:0]   reg_idx;
        logic [GAP_W-1:0]       reg_val;
        logic [FRAME_W-1:0]     frame;
        logic [PEAK_BIN_W-1:0]  bin;
        logic                   sos;
        logic                   known;
        logic [5:0]             n_known;
        logic [HASH_W-1:0]      t_hash;
        logic [FRAME_W-1:0]     t_afrm;
    } t_stim_row;

    typedef struct packed {
        logic [HASH_W-1:0]  pair_hash;
        logic [FRAME_W-1:0] anchor_frm;
        logic               last_flag;
    } t_fingerprint;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [GAP_W-1:0]      i_cfg_data;
    logic                  i_peak_valid;
    logic                  o_peak_ready;
    logic [FRAME_W-1:0]    i_peak_frame;
    logic [PEAK_BIN_W-1:0] i_peak_bin;
    logic                  i_start_of_signal;
    logic                  o_hash_valid;
    logic                  i_hash_ready;
    logic [HASH_W-1:0]     o_pair_hash;
    logic [FRAME_W-1:0]    o_anchor_frame;
    logic                  o_last_of_run;

    // Shadow of the anchor ring and the registers, kept in step with the block
    logic [FRAME_W-1:0]    anc_frame [N_ANCHORS];
    logic [PEAK_BIN_W-1:0] anc_bin   [N_ANCHORS];
    logic [FAN_W-1:0]      anc_count [N_ANCHORS];
    logic                  anc_live  [N_ANCHORS];
    int                    ring_head;
    logic [FAN_W-1:0]      cfg_fan_out;
    logic [GAP_W-1:0]      cfg_min_gap;
    logic [GAP_W-1:0]      cfg_max_gap;

    t_fingerprint pair_batch [$];   // fingerprints of the peak just taken
    t_fingerprint fp_expected [$];  // fingerprints still owed by the block
    t_stim_row    stim_table [$];
    int           mismatch_cnt;
    bit           no_gaps;

    peak_pair_landmark_hasher_core #(
        .ANCHOR_DEPTH(N_ANCHORS),
        .BIN_BITS    (PEAK_BIN_W)
    ) dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .i_peak_valid     (i_peak_valid),
        .o_peak_ready     (o_peak_ready),
        .i_peak_frame     (i_peak_frame),
        .i_peak_bin       (i_peak_bin),
        .i_start_of_signal(i_start_of_signal),
        .o_hash_valid     (o_hash_valid),
        .i_hash_ready     (i_hash_ready),
        .o_pair_hash      (o_pair_hash),
        .o_anchor_frame   (o_anchor_frame),
        .o_last_of_run    (o_last_of_run)
    );

    always #5 i_clk = ~i_clk;

    // Watchdog: a healthy run ends far sooner than this.
    initial begin
        #20_000_000;
        $display("peak_pair_landmark_hasher_core verification failed");
        $finish;
    end

    function automatic t_stim_row mk_peak(input logic [FRAME_W-1:0] frame,
                                          input logic [PEAK_BIN_W-1:0] bin,
                                          input logic sos);
        t_stim_row r;
        r = '0;
        r.kind  = ROW_PEAK;
        r.frame = frame;
        r.bin   = bin;
        r.sos   = sos;
        return r;
    endfunction

    function automatic t_stim_row mk_known(input logic [FRAME_W-1:0] frame,
                                           input logic [PEAK_BIN_W-1:0] bin,
                                           input logic sos, input int n,
                                           input logic [HASH_W-1:0] hash,
                                           input logic [FRAME_W-1:0] afrm);
        t_stim_row r;
        r = mk_peak(frame, bin, sos);
        r.known   = 1'b1;
        r.n_known = 6'(n);
        r.t_hash  = hash;
        r.t_afrm  = afrm;
        return r;
    endfunction

    function automatic t_stim_row mk_reg(input logic [CFG_IDX_W-1:0] idx,
                                         input logic [GAP_W-1:0] val);
        t_stim_row r;
        r = '0;
        r.kind    = ROW_REG;
        r.reg_idx = idx;
        r.reg_val = val;
        return r;
    endfunction

    task automatic flag_mismatch(input string msg);
        mismatch_cnt++;
        if (mismatch_cnt <= 10) begin
            $display("%0t: mismatch: %s", $time, msg);
        end
    endtask

    task automatic drop_all_anchors();
        for (int k = 0; k < N_ANCHORS; k++) begin
            anc_frame[k] = '0;
            anc_bin[k]   = '0;
            anc_count[k] = '0;
            anc_live[k]  = 1'b0;
        end
        ring_head = 0;
    endtask

    // Pair one peak against the ring, oldest slot first, and store it as the
    // newest anchor. The fingerprints land in pair_batch.
    task automatic predict_pairs(input logic [FRAME_W-1:0] frame,
                                 input logic [PEAK_BIN_W-1:0] bin,
                                 input logic sos);
        int                 slot;
        logic [FRAME_W-1:0] gap;
        logic [HASH_W-1:0]  h;
        t_fingerprint       fp;
        pair_batch.delete();
        if (sos) begin
            drop_all_anchors();
        end
        for (int k = 0; k < N_ANCHORS; k++) begin
            slot = (ring_head + k) % N_ANCHORS;
            gap  = frame - anc_frame[slot];
            if (!anc_live[slot]) begin
                // empty slot, skip
            end else if (anc_count[slot] >= cfg_fan_out) begin
                anc_live[slot] = 1'b0;
            end else if (anc_frame[slot] > frame) begin
                // anchor lies ahead of the peak: no pair, keep it
            end else if (gap > FRAME_W'(cfg_max_gap)) begin
                anc_live[slot] = 1'b0;
            end else if (gap >= FRAME_W'(cfg_min_gap) && pair_batch.size() < MAX_RESULTS) begin
                h = HASH_W'(anc_bin[slot]);
                h = h * HASH_MUL + HASH_W'(bin);
                h = h * HASH_MUL + HASH_W'(gap);
                fp.pair_hash  = h;
                fp.anchor_frm = anc_frame[slot];
                fp.last_flag  = 1'b0;
                pair_batch.insert(pair_batch.size(), fp);
                anc_count[slot] = anc_count[slot] + FAN_W'(1);
                if (anc_count[slot] >= cfg_fan_out) begin
                    anc_live[slot] = 1'b0;
                end
            end
        end
        if (pair_batch.size() > 0) begin
            fp = pair_batch.pop_back();
            fp.last_flag = 1'b1;
            pair_batch.insert(pair_batch.size(), fp);
        end
        anc_frame[ring_head] = frame;
        anc_bin[ring_head]   = bin;
        anc_count[ring_head] = '0;
        anc_live[ring_head]  = 1'b1;
        ring_head = (ring_head + 1) % N_ANCHORS;
    endtask

    // Present one peak, hold it until the transfer, then queue what it owes.
    task automatic send_peak(input t_stim_row r);
        t_fingerprint typed;
        while (!no_gaps && $urandom_range(0, 99) < IDLE_PCT) begin
            @(negedge i_clk);
            i_peak_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_peak_valid      <= 1'b1;
        i_peak_frame      <= r.frame;
        i_peak_bin        <= r.bin;
        i_start_of_signal <= r.sos;
        do @(posedge i_clk); while (!o_peak_ready);
        predict_pairs(r.frame, r.bin, r.sos);
        if (r.known) begin
            // hand-typed outcome replaces the predicted one
            if (r.n_known == 6'd1) begin
                typed.pair_hash  = r.t_hash;
                typed.anchor_frm = r.t_afrm;
                typed.last_flag  = 1'b1;
                fp_expected.insert(fp_expected.size(), typed);
            end
        end else begin
            foreach (pair_batch[i]) begin
                fp_expected.insert(fp_expected.size(), pair_batch[i]);
            end
        end
    endtask

    // Drop valid and hold off until every owed fingerprint has arrived and the
    // last scan has surely finished.
    task automatic drain_block();
        @(negedge i_clk);
        i_peak_valid <= 1'b0;
        while (fp_expected.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (N_ANCHORS + 8) @(posedge i_clk);
    endtask

    task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [GAP_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        case (idx)
            CFG_FAN_OUT: cfg_fan_out = val[FAN_W-1:0];
            CFG_MIN_GAP: cfg_min_gap = val;
            CFG_MAX_GAP: cfg_max_gap = val;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Receiver: stall at random, except during the no-idle stretch.
    always @(negedge i_clk) begin
        i_hash_ready <= no_gaps || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // Check every fingerprint transfer against the oldest owed one.
    always @(posedge i_clk) begin : fp_check
        t_fingerprint want;
        if (i_rst_n && o_hash_valid && i_hash_ready) begin
            if (fp_expected.size() == 0) begin
                flag_mismatch($sformatf("unexpected fingerprint hash %h anchor %h last %b",
                                        o_pair_hash, o_anchor_frame, o_last_of_run));
            end else begin
                want = fp_expected.pop_front();
                if (want.pair_hash !== o_pair_hash || want.anchor_frm !== o_anchor_frame
                        || want.last_flag !== o_last_of_run) begin
                    flag_mismatch($sformatf(
                        "hash exp %h got %h, anchor exp %h got %h, last exp %b got %b",
                        want.pair_hash, o_pair_hash, want.anchor_frm, o_anchor_frame,
                        want.last_flag, o_last_of_run));
                end
            end
        end
    end

    initial begin
        logic [FRAME_W-1:0]    frame;
        logic [PEAK_BIN_W-1:0] bin;
        logic                  sos;
        logic [FAN_W-1:0]      fan;
        logic [GAP_W-1:0]      gmin;
        logic [GAP_W-1:0]      gmax;
        int                    step_max;
        int                    jump_pct;
        int                    len;
        int                    phase;
        int                    rand_sent;

        // Drive every input to a known value from time zero.
        i_clk             = 1'b0;
        i_rst_n           = 1'b0;
        i_cfg_we          = 1'b0;
        i_cfg_idx         = CFG_FAN_OUT;
        i_cfg_data        = '0;
        i_peak_valid      = 1'b0;
        i_peak_frame      = '0;
        i_peak_bin        = '0;
        i_start_of_signal = 1'b0;
        i_hash_ready      = 1'b0;
        no_gaps           = 1'b0;
        mismatch_cnt      = 0;
        cfg_fan_out       = FAN_OUT_RST;
        cfg_min_gap       = MIN_GAP_RST;
        cfg_max_gap       = MAX_GAP_RST;
        drop_all_anchors();

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part. Reset gives fan-out 5 and a gap window of 1 to 64.
        stim_table = '{
            mk_known(20'd0, 12'd0, 1'b1, 0, '0, '0),         // empty ring
            mk_known(20'd1, 12'd1, 1'b0, 1, 32'd1000004, 20'd0),
            mk_known(20'd1, 12'hFFF, 1'b0, 1, 32'd4095012286, 20'd0),
            mk_peak(20'd64, 12'hAAA, 1'b0),                 // gap right at max
            mk_peak(20'd129, 12'h555, 1'b0),                // all past max, retire
            mk_peak(20'd100, 12'd7, 1'b0),                  // frame steps back
            mk_peak(20'd130, 12'd8, 1'b0),                  // the skipped anchor still pairs
            mk_known(20'hFFFFF, 12'hFFF, 1'b1, 0, '0, '0),  // start flag clears ring
            mk_known(20'hFFFFF, 12'd0, 1'b0, 0, '0, '0),    // gap zero below min
            mk_reg(CFG_FAN_OUT, 10'd0),
            mk_known(20'd10, 12'd1, 1'b1, 0, '0, '0),
            mk_known(20'd11, 12'd2, 1'b0, 0, '0, '0),       // zero fan-out retires
            mk_reg(CFG_FAN_OUT, 10'd15),
            mk_reg(CFG_MIN_GAP, 10'd0),
            mk_reg(CFG_MAX_GAP, 10'd0),
            mk_peak(20'd11, 12'd3, 1'b0),                   // gap zero pairs
            mk_peak(20'd11, 12'd4, 1'b0),
            mk_peak(20'd12, 12'd5, 1'b0),
            mk_reg(CFG_MIN_GAP, 10'd1023),
            mk_reg(CFG_MAX_GAP, 10'd1023),
            mk_peak(20'd0, 12'd6, 1'b1),
            mk_peak(20'd1023, 12'd9, 1'b0),                 // widest gap
            mk_peak(20'd1024, 12'd10, 1'b0),
            mk_reg(CFG_MIN_GAP, 10'd10),
            mk_reg(CFG_MAX_GAP, 10'd5),                     // window empty
            mk_peak(20'd2000, 12'd1, 1'b1),
            mk_peak(20'd2003, 12'd2, 1'b0),
            mk_peak(20'd2010, 12'd3, 1'b0),
            mk_reg(CFG_FAN_OUT, 10'd1),
            mk_reg(CFG_MIN_GAP, 10'd1),
            mk_reg(CFG_MAX_GAP, 10'd1023),
            mk_peak(20'd5, 12'd1, 1'b1),
            mk_peak(20'd6, 12'd2, 1'b0),                    // fan-out of one used up
            mk_peak(20'd7, 12'd3, 1'b0)
        };
        foreach (stim_table[i]) begin
            if (stim_table[i].kind == ROW_REG) begin
                drain_block();
                set_reg(stim_table[i].reg_idx, stim_table[i].reg_val);
            end else begin
                send_peak(stim_table[i]);
            end
        end

        // Random part: phases of ordered peak runs, each under its own settings.
        rand_sent = 0;
        phase     = 0;
        while (rand_sent < RAND_ITEMS) begin
            drain_block();
            jump_pct = 0;
            if ($urandom_range(0, 3) == 0) begin
                // dense run: many anchors build up, then jump past min to pair them all
                fan      = 4'd15;
                gmin     = GAP_W'($urandom_range(20, 100));
                gmax     = 10'd1023;
                step_max = 1;
                jump_pct = 12;
            end else begin
                case ($urandom_range(0, 5))
                    0: fan = 4'd0;
                    1: fan = 4'd15;
                    default: fan = FAN_W'($urandom_range(1, 14));
                endcase
                gmin = ($urandom_range(0, 5) == 0) ? GAP_W'($urandom_range(0, 1023))
                                                   : GAP_W'($urandom_range(0, 4));
                case ($urandom_range(0, 5))
                    0: gmax = 10'd0;
                    1: gmax = 10'd1023;
                    2: gmax = 10'd64;
                    default: gmax = GAP_W'($urandom_range(1, 300));
                endcase
                step_max = int'(gmax) / 4 + 1;
            end
            set_reg(CFG_FAN_OUT, {6'd0, fan});
            set_reg(CFG_MIN_GAP, gmin);
            set_reg(CFG_MAX_GAP, gmax);

            // one long phase with neither side idling
            no_gaps = (phase == 2);
            len     = no_gaps ? 60 : $urandom_range(20, 60);
            frame   = FRAME_W'($urandom);
            for (int i = 0; i < len && rand_sent < RAND_ITEMS; i++) begin
                if (i > 0 && $urandom_range(0, 39) == 0) begin
                    drain_block();
                end
                bin = PEAK_BIN_W'($urandom);
                sos = 1'b0;
                if (i == 0) begin
                    sos = 1'b1;
                end else if ($urandom_range(0, 99) < 12) begin
                    // noise: any frame, backwards included, sometimes a restart
                    frame = FRAME_W'($urandom);
                    sos   = ($urandom_range(0, 3) == 0);
                end else begin
                    frame = frame + FRAME_W'($urandom_range(0, step_max));
                    if ($urandom_range(0, 99) < jump_pct) begin
                        frame = frame + FRAME_W'(gmin);
                    end
                end
                send_peak(mk_peak(frame, bin, sos));
                rand_sent++;
            end
            no_gaps = 1'b0;
            phase++;
        end

        // Wind down: wait for every owed fingerprint, then watch for strays.
        drain_block();
        repeat (2 * N_ANCHORS) @(posedge i_clk);
        if (fp_expected.size() != 0) begin
            flag_mismatch($sformatf("%0d fingerprints never arrived", fp_expected.size()));
        end
        if (mismatch_cnt == 0) begin
            $display("peak_pair_landmark_hasher_core verification clean");
        end else begin
            $display("peak_pair_landmark_hasher_core verification failed");
        end
        $finish;
    end

endmodule
